// ===== rtl/ebd_pkg.sv =====
`timescale 1ns / 1ps

package ebd_pkg;

   // Field widths
   localparam int unsigned CountWidth = 15;
   localparam int unsigned SpeedWidth = 8;
   localparam int unsigned FloorWidth = 7;
   localparam int unsigned DutyWidth  = 8;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 15;
   localparam int unsigned RspDataWidth = 56;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   localparam logic [FloorWidth-1:0] FloorReset = 7'd17;
   localparam logic signed [SpeedWidth-1:0] SpeedLimit = 8'sd100;

   // Duty = floor(mag * 255 / 100) as mag * 255 * 5243 >> 19, exact for mag <= 100
   localparam int unsigned DutyMulWidth = 28;
   localparam logic [20:0] DutyRecip = 21'd1336965;
   localparam int unsigned DutyShift = 19;

   // Configuration register indexes
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_TICK_TARGET = 2'd0,
      CSR_BASE_SPEED  = 2'd1,
      CSR_FLOOR_SPEED = 2'd2
   } csr_index_type;

   // Request kinds
   typedef enum logic {
      FUNC_START  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   // Wheel drive modes
   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_FWD   = 2'd1,
      MODE_REV   = 2'd2,
      MODE_BRAKE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [DutyWidth-1:0]  duty;
   } drive_type;

   // Map a signed speed in percent to a drive mode and PWM duty
   function automatic drive_type drive_of(input logic signed [SpeedWidth-1:0] speed);
      drive_type                 result;
      logic [SpeedWidth-1:0]     mag;
      logic [FloorWidth-1:0]     mag_sat;
      logic [DutyMulWidth-1:0]   prod;
      mag = speed[SpeedWidth-1] ? SpeedWidth'(-speed) : speed;
      mag_sat = (mag > 8'd100) ? 7'd100 : mag[FloorWidth-1:0];
      prod = DutyMulWidth'(mag_sat) * DutyMulWidth'(DutyRecip);
      if (speed == '0) begin
         result.mode = MODE_OFF;
         result.duty = '0;
      end else begin
         result.mode = speed[SpeedWidth-1] ? MODE_REV : MODE_FWD;
         result.duty = prod[DutyShift +: DutyWidth];
      end
      return result;
   endfunction

endpackage

// ===== rtl/encoder_balanced_drive.sv =====
`timescale 1ns / 1ps

// Two-wheel encoder-balanced drive controller.
// req channel: one beat per command. req_tuser selects start (0) or sample (1);
//   req_tdata carries the two encoder line levels. A start latches the levels,
//   clears both edge counts and loads the left speed from base_speed and the
//   right speed with half of it. Each sample counts level changes per wheel
//   and trims the speeds so the counts stay level; when either count reaches
//   tick_target both wheels brake and done is flagged.
// rsp channel: exactly one beat per request with modes, duties, edge counts
//   and done.
// csr port: write-only, csr_addr 0 tick_target, 1 base_speed, 2 floor_speed;
//   write only while no request is in flight.
// Path: the input register, then the update logic feeding the response
//   register. Throughput is one beat per cycle while rsp_tready is high; the
//   state update is a single compare/increment pass, so nothing iterates.
// Reset clears the pipeline, the move state and the registers (floor 17).
// When rsp_tready is low the response register holds, the input register
//   fills, and req_tready drops once both are occupied.
module encoder_balanced_drive (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] enc_left, [1] enc_right, [7:2] zero
   input  logic         req_tuser,   // [0] func
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] left_mode, [9:2] left_duty, [11:10] right_mode, [19:12] right_duty,
   // [34:20] left_edges, [49:35] right_edges, [50] done_res, [55:51] zero
   output logic [ebd_pkg::RspDataWidth-1:0] rsp_tdata,
   // configuration
   input  logic                              csr_we,
   input  logic [ebd_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [ebd_pkg::CsrDataWidth-1:0]  csr_wdata
);

   localparam int unsigned CW = ebd_pkg::CountWidth;
   localparam int unsigned SW = ebd_pkg::SpeedWidth;
   localparam int unsigned FW = ebd_pkg::FloorWidth;

   // configuration registers
   logic [CW-1:0]        tick_target_ff;
   logic signed [SW-1:0] base_speed_ff;
   logic [FW-1:0]        floor_speed_ff;

   // input register
   logic                 s1_valid_ff;
   ebd_pkg::func_type    s1_func_ff;
   logic                 s1_left_ff;
   logic                 s1_right_ff;

   // move state
   logic                 left_level_ff,  left_level_in;
   logic                 right_level_ff, right_level_in;
   logic [CW-1:0]        left_count_ff,  left_count_in;
   logic [CW-1:0]        right_count_ff, right_count_in;
   logic signed [SW-1:0] left_speed_ff,  left_speed_in;
   logic signed [SW-1:0] right_speed_ff, right_speed_in;
   logic                 running_ff,     running_in;

   // response register
   logic                                rsp_valid_ff;
   logic [ebd_pkg::RspDataWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic advance;

   // handshake: input stage moves on when the response register is empty or being read
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_target_ff <= '0;
         base_speed_ff  <= '0;
         floor_speed_ff <= ebd_pkg::FloorReset;
      end else if (csr_we) begin
         unique case (csr_addr)
            ebd_pkg::CSR_TICK_TARGET: tick_target_ff <= csr_wdata[CW-1:0];
            ebd_pkg::CSR_BASE_SPEED:  base_speed_ff  <= csr_wdata[SW-1:0];
            ebd_pkg::CSR_FLOOR_SPEED: floor_speed_ff <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_func_ff  <= ebd_pkg::func_type'(req_tuser);
         s1_left_ff  <= req_tdata[0];
         s1_right_ff <= req_tdata[1];
      end
   end

   // update logic: one pass per beat
   always_comb begin
      logic signed [SW-1:0] base;
      logic signed [SW-1:0] half;
      logic signed [SW:0]   flr;
      logic                 done;
      logic                 brake;
      ebd_pkg::drive_type   left_drv;
      ebd_pkg::drive_type   right_drv;

      // saturate base to +-100 and halve toward zero
      if (base_speed_ff > ebd_pkg::SpeedLimit) begin
         base = ebd_pkg::SpeedLimit;
      end else if (base_speed_ff < -ebd_pkg::SpeedLimit) begin
         base = -ebd_pkg::SpeedLimit;
      end else begin
         base = base_speed_ff;
      end
      half = (base + $signed({{(SW-1){1'b0}}, base[SW-1]})) >>> 1;
      flr  = $signed({2'b00, floor_speed_ff});

      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      left_speed_in  = left_speed_ff;
      right_speed_in = right_speed_ff;
      running_in     = running_ff;
      done           = 1'b0;
      brake          = 1'b0;
      left_drv       = ebd_pkg::drive_of(base);
      right_drv      = ebd_pkg::drive_of(base);

      if (s1_func_ff == ebd_pkg::FUNC_START) begin
         left_level_in  = s1_left_ff;
         right_level_in = s1_right_ff;
         left_count_in  = '0;
         right_count_in = '0;
         left_speed_in  = base;
         right_speed_in = half;
         running_in     = 1'b1;
         if (tick_target_ff == '0) begin
            running_in = 1'b0;
            done       = 1'b1;
         end
      end else if (running_ff) begin
         // count level changes, saturating
         if (s1_left_ff != left_level_ff) begin
            left_level_in = s1_left_ff;
            if (left_count_ff != ebd_pkg::CountMax) begin
               left_count_in = left_count_ff + 1'b1;
            end
         end
         if (s1_right_ff != right_level_ff) begin
            right_level_in = s1_right_ff;
            if (right_count_ff != ebd_pkg::CountMax) begin
               right_count_in = right_count_ff + 1'b1;
            end
         end
         // slow the leader, speed up the trailer
         if (left_count_in < right_count_in) begin
            if ($signed({right_speed_ff[SW-1], right_speed_ff}) > flr) begin
               right_speed_in = right_speed_ff - 8'sd1;
            end
            if (left_speed_ff < base) begin
               left_speed_in = left_speed_ff + 8'sd1;
            end
         end else if (left_count_in > right_count_in) begin
            if ($signed({left_speed_ff[SW-1], left_speed_ff}) > flr) begin
               left_speed_in = left_speed_ff - 8'sd1;
            end
            if (right_speed_ff < base) begin
               right_speed_in = right_speed_ff + 8'sd1;
            end
         end
         left_drv  = ebd_pkg::drive_of(left_speed_in);
         right_drv = ebd_pkg::drive_of(right_speed_in);
         if (left_count_in >= tick_target_ff || right_count_in >= tick_target_ff) begin
            running_in = 1'b0;
            done       = 1'b1;
         end
      end else begin
         brake = 1'b1;
      end

      if (done || brake) begin
         left_drv.mode  = ebd_pkg::MODE_BRAKE;
         left_drv.duty  = '0;
         right_drv.mode = ebd_pkg::MODE_BRAKE;
         right_drv.duty = '0;
      end

      rsp_data_in = {5'd0, done, right_count_in, left_count_in,
                     right_drv.duty, right_drv.mode, left_drv.duty, left_drv.mode};
   end

   // move state advances with each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         left_level_ff  <= 1'b0;
         right_level_ff <= 1'b0;
         left_count_ff  <= '0;
         right_count_ff <= '0;
         left_speed_ff  <= '0;
         right_speed_ff <= '0;
         running_ff     <= 1'b0;
      end else if (advance) begin
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         left_speed_ff  <= left_speed_in;
         right_speed_ff <= right_speed_in;
         running_ff     <= running_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
